// ----- src/edit_distance_engine_unit_macros.svh -----
// Assertion macros shared by the checker of the edit distance engine.
`ifndef EDIT_DISTANCE_ENGINE_UNIT_MACROS_SVH
`define EDIT_DISTANCE_ENGINE_UNIT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is applied.
`define EDE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Next-cycle implication built on the macro above.
`define EDE_ASSERT_NEXT(label, ante, cons, msg) \
	`EDE_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- src/ede_pkg.sv -----
// Shared codes, field types and the cell control struct of the edit distance engine.
package ede_pkg;

	localparam int KIND_W = 2;
	localparam int SYM_W  = 8;
	localparam int DIST_W = 7;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [SYM_W-1:0]  sym_t;
	typedef logic [DIST_W-1:0] dist_t;

	localparam kind_t KIND_APPEND = 2'd0;
	localparam kind_t KIND_FEED   = 2'd1;
	localparam kind_t KIND_EMIT   = 2'd2;
	localparam kind_t KIND_CLEAR  = 2'd3;

	typedef struct packed {
		logic restart;
		logic load_sym;
	} cell_ctrl_t;

endpackage

// ----- src/ede_in_if.sv -----
// Input channel of the edit distance engine: command kind and symbol byte.
interface ede_in_if;
	import ede_pkg::*;

	logic  valid;
	logic  ready;
	kind_t kind;
	sym_t  symbol;

	modport source (output valid, output kind, output symbol, input ready);
	modport sink (input valid, input kind, input symbol, output ready);
endinterface

// ----- src/ede_out_if.sv -----
// Result channel of the edit distance engine: distance and overflow flag.
interface ede_out_if;
	import ede_pkg::*;

	logic  valid;
	logic  ready;
	dist_t distance;
	logic  overflow;

	modport source (output valid, output distance, output overflow, input ready);
	modport sink (input valid, input distance, input overflow, output ready);
endinterface

// ----- src/ede_cell.sv -----
// One cell of the systolic row: holds a first-string byte and one column entry.
module ede_cell #(
	parameter int IDX = 1,
	parameter int DW  = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ede_pkg::cell_ctrl_t ctrl,
	input  ede_pkg::sym_t      load_val,
	input  logic               prev_valid,
	input  ede_pkg::sym_t      prev_sym,
	input  logic [DW-1:0]      prev_new,
	input  logic [DW-1:0]      prev_old,
	output logic               nxt_valid,
	output ede_pkg::sym_t      nxt_sym,
	output logic [DW-1:0]      nxt_new,
	output logic [DW-1:0]      nxt_old,
	output logic [DW-1:0]      entry_val
);
	import ede_pkg::*;

	sym_t          sym_q;
	logic [DW-1:0] d_q;
	logic          nxt_valid_q;
	sym_t          nxt_sym_q;
	logic [DW-1:0] nxt_new_q;
	logic [DW-1:0] nxt_old_q;

	logic          cost;
	logic [DW:0]   up_cost;
	logic [DW:0]   left_cost;
	logic [DW:0]   diag_cost;
	logic [DW:0]   min_ul;
	logic [DW:0]   min_all;

	// Unit-cost recurrence: deletion from above, insertion from the left
	// neighbor's new value, substitution from its old value.
	always_comb begin
		cost      = (sym_q != prev_sym);
		up_cost   = {1'b0, d_q} + {{DW{1'b0}}, 1'b1};
		left_cost = {1'b0, prev_new} + {{DW{1'b0}}, 1'b1};
		diag_cost = {1'b0, prev_old} + {{DW{1'b0}}, cost};
		min_ul    = (up_cost < left_cost) ? up_cost : left_cost;
		min_all   = (min_ul < diag_cost) ? min_ul : diag_cost;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_sym) begin
			sym_q <= load_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q         <= DW'(IDX);
			nxt_valid_q <= 1'b0;
		end else if (ctrl.restart) begin
			d_q         <= DW'(IDX);
			nxt_valid_q <= 1'b0;
		end else begin
			nxt_valid_q <= prev_valid;
			if (prev_valid) begin
				d_q <= min_all[DW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (prev_valid) begin
			nxt_sym_q <= prev_sym;
			nxt_new_q <= min_all[DW-1:0];
			nxt_old_q <= d_q;
		end
	end

	assign nxt_valid = nxt_valid_q;
	assign nxt_sym   = nxt_sym_q;
	assign nxt_new   = nxt_new_q;
	assign nxt_old   = nxt_old_q;
	assign entry_val = d_q;

endmodule

// ----- src/edit_distance_engine_unit.sv -----
// Top level of the edit distance engine: a systolic row of MAX_LEN cells.
// Append, clear and second-string transactions are always taken; a second-string byte
// enters the row every cycle and its wavefront passes the entry stage, then each cell.
// An end transaction is held until the row has drained and the output register is free;
// its result is registered and shown in the cycle after acceptance.
// Reset (arst_n low) empties both strings, clears the overflow flag and loads entry i with i.
module edit_distance_engine_unit #(
	parameter int MAX_LEN = 64
) (
	input logic clk,
	input logic arst_n,
	ede_in_if.sink    item,
	ede_out_if.source result
);
	import ede_pkg::*;

	localparam int DW = $clog2(MAX_LEN + 1);
	localparam logic [DW-1:0] LEN_MAX = DW'(MAX_LEN);

	// Control and length state.
	logic [DW-1:0] first_len_q;
	logic [DW-1:0] second_len_q;
	logic [DW-1:0] drain_q;
	logic          trunc_q;

	// Entry stage of the wavefront: the new and old values of row entry 0.
	logic          w0_valid_q;
	sym_t          w0_sym_q;
	logic [DW-1:0] w0_new_q;
	logic [DW-1:0] w0_old_q;

	// Output register, which parts the result side from the input side.
	logic          out_valid_q;
	dist_t         out_dist_q;
	logic          out_ovf_q;

	// Signals between neighboring cells; index 0 is the entry stage.
	logic          wave_valid [0:MAX_LEN];
	sym_t          wave_sym   [0:MAX_LEN];
	logic [DW-1:0] wave_new   [0:MAX_LEN];
	logic [DW-1:0] wave_old   [0:MAX_LEN];
	logic [DW-1:0] row        [0:MAX_LEN];

	logic                 accept;
	logic                 emit_ok;
	logic                 restart;
	logic                 append_ok;
	logic                 feed_ok;
	logic [DW+DIST_W-1:0] row_ext;

	// An end transaction needs the row settled and the output register free.
	// All other kinds are always taken: an append that arrives during a second
	// string is dropped without effect, so it never has to wait for the row.
	assign emit_ok = (drain_q == '0) && (!out_valid_q || result.ready);

	always_comb begin
		unique case (item.kind)
			KIND_APPEND: item.ready = 1'b1;
			KIND_FEED:   item.ready = 1'b1;
			KIND_EMIT:   item.ready = emit_ok;
			KIND_CLEAR:  item.ready = 1'b1;
			default:     item.ready = 1'b1;
		endcase
	end

	assign accept    = item.valid && item.ready;
	assign restart   = accept && ((item.kind == KIND_EMIT) || (item.kind == KIND_CLEAR));
	assign append_ok = accept && (item.kind == KIND_APPEND) && (second_len_q == '0)
		&& (first_len_q != LEN_MAX);
	assign feed_ok   = accept && (item.kind == KIND_FEED) && (second_len_q != LEN_MAX);

	// Entry 0 of the column always equals the second-string length.
	assign wave_valid[0] = w0_valid_q;
	assign wave_sym[0]   = w0_sym_q;
	assign wave_new[0]   = w0_new_q;
	assign wave_old[0]   = w0_old_q;
	assign row[0]        = second_len_q;

	// The row of cells. Cells past the first-string length also compute, but
	// their entries are never selected and are restored on the next restart.
	for (genvar y = 1; y <= MAX_LEN; y++) begin : g_cell
		cell_ctrl_t ctrl;

		assign ctrl.restart  = restart;
		assign ctrl.load_sym = append_ok && (first_len_q == DW'(y - 1));

		ede_cell #(
			.IDX (y),
			.DW  (DW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.load_val   (item.symbol),
			.prev_valid (wave_valid[y-1]),
			.prev_sym   (wave_sym[y-1]),
			.prev_new   (wave_new[y-1]),
			.prev_old   (wave_old[y-1]),
			.nxt_valid  (wave_valid[y]),
			.nxt_sym    (wave_sym[y]),
			.nxt_new    (wave_new[y]),
			.nxt_old    (wave_old[y]),
			.entry_val  (row[y])
		);
	end

	// The distance field carries the low bits of the selected entry.
	assign row_ext = {{DIST_W{1'b0}}, row[first_len_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q  <= '0;
			second_len_q <= '0;
			drain_q      <= '0;
			trunc_q      <= 1'b0;
			w0_valid_q   <= 1'b0;
		end else begin
			w0_valid_q <= feed_ok;
			// A new byte rearms the drain counter; a clear abandons the wavefront.
			if (feed_ok) begin
				drain_q <= LEN_MAX;
			end else if (accept && (item.kind == KIND_CLEAR)) begin
				drain_q <= '0;
			end else if (drain_q != '0) begin
				drain_q <= drain_q - DW'(1);
			end
			if (accept) begin
				unique case (item.kind)
					KIND_APPEND: begin
						if (append_ok) begin
							first_len_q <= first_len_q + DW'(1);
						end else if (second_len_q == '0) begin
							trunc_q <= 1'b1;
						end
					end
					KIND_FEED: begin
						if (feed_ok) begin
							second_len_q <= second_len_q + DW'(1);
						end else begin
							trunc_q <= 1'b1;
						end
					end
					KIND_EMIT: begin
						second_len_q <= '0;
					end
					KIND_CLEAR: begin
						first_len_q  <= '0;
						second_len_q <= '0;
						trunc_q      <= 1'b0;
					end
					default: begin
						second_len_q <= second_len_q;
					end
				endcase
			end
		end
	end

	// Entry-stage payload: the wavefront carries the byte and entry 0 before
	// and after the update.
	always_ff @(posedge clk) begin
		if (feed_ok) begin
			w0_sym_q <= item.symbol;
			w0_new_q <= second_len_q + DW'(1);
			w0_old_q <= second_len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && (item.kind == KIND_EMIT)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (item.kind == KIND_EMIT)) begin
			out_dist_q <= row_ext[DIST_W-1:0];
			out_ovf_q  <= trunc_q;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.distance = out_dist_q;
	assign result.overflow = out_ovf_q;

endmodule

// ----- src/ede_checker.sv -----
// Port-level assertions for the edit distance engine and their bind statement.
`include "edit_distance_engine_unit_macros.svh"

module ede_checker #(
	parameter int MAX_LEN = 64
) (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input ede_pkg::kind_t in_kind,
	input logic           out_valid,
	input logic           out_ready,
	input ede_pkg::dist_t out_distance,
	input logic           out_overflow
);
	import ede_pkg::*;

	logic emit_taken;
	logic big_len;

	assign emit_taken = in_valid && in_ready && (in_kind == KIND_EMIT);
	assign big_len    = (MAX_LEN > 127);

	`EDE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`EDE_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_distance) && $stable(out_overflow), "stalled result changed")
	`EDE_ASSERT_NEXT(a_emit_result, emit_taken, out_valid, "end transaction gave no result")
	`EDE_ASSERT(a_dist_range, out_valid |-> (big_len || (out_distance <= MAX_LEN)), "distance above maximum length")
	`EDE_ASSERT(a_emit_wait, (out_valid && !out_ready) |-> !emit_taken, "end taken while result pending")

endmodule

bind edit_distance_engine_unit ede_checker #(
	.MAX_LEN (MAX_LEN)
) u_ede_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item.valid),
	.in_ready     (item.ready),
	.in_kind      (item.kind),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_distance (result.distance),
	.out_overflow (result.overflow)
);
